### sv/fisn_pkg.sv
// package: float types, constants and pipelined multiply/add step functions
`default_nettype none
package fisn_pkg;

    localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
    localparam logic [31:0] MAGIC_RESET = 32'h5F37_59DF;
    localparam logic [31:0] F_HALF      = 32'h3F00_0000;
    localparam logic [31:0] F_THREE_HALF = 32'h3FC0_0000;
    localparam logic [7:0]  EXP_MAX     = 8'hFF;

    typedef struct packed {
        logic               nan;
        logic               inf;
        logic               zero;
        logic               sign;
        logic signed [10:0] e;
        logic [47:0]        p;
    } t_mul_mid;

    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        inf_sign;
        logic        sign;
        logic        sub;
        logic        zero_sign;
        logic [7:0]  e;
        logic [26:0] big;
        logic [26:0] sml;
    } t_add_mid;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] lz;
        logic       found;
        lz    = '0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && v[i]) begin
                lz    = 6'(47 - i);
                found = 1'b1;
            end
        end
        return lz;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] lz;
        logic       found;
        lz    = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && v[i]) begin
                lz    = 5'(26 - i);
                found = 1'b1;
            end
        end
        return lz;
    endfunction

    // multiply, first half: classify and form the mantissa product
    function automatic t_mul_mid mul_pre(input logic [31:0] a, input logic [31:0] b);
        t_mul_mid   m;
        logic [7:0] ea, eb, eae, ebe;
        logic       an, bn, ai, bi, az, bz;
        logic [23:0] ma, mb;
        ea  = a[30:23];
        eb  = b[30:23];
        an  = (ea == EXP_MAX) && (a[22:0] != '0);
        bn  = (eb == EXP_MAX) && (b[22:0] != '0);
        ai  = (ea == EXP_MAX) && (a[22:0] == '0);
        bi  = (eb == EXP_MAX) && (b[22:0] == '0);
        az  = (a[30:0] == '0);
        bz  = (b[30:0] == '0);
        eae = (ea == '0) ? 8'd1 : ea;
        ebe = (eb == '0) ? 8'd1 : eb;
        ma  = {ea != '0, a[22:0]};
        mb  = {eb != '0, b[22:0]};
        m.nan  = an | bn | (ai & bz) | (az & bi);
        m.inf  = ai | bi;
        m.zero = az | bz;
        m.sign = a[31] ^ b[31];
        m.e    = $signed({3'b000, eae}) + $signed({3'b000, ebe}) - 11'sd126;
        m.p    = ma * mb;
        return m;
    endfunction

    // multiply, second half: normalize, denormalize and round to nearest even
    function automatic logic [31:0] mul_post(input t_mul_mid m);
        logic [5:0]         lz;
        logic [47:0]        pn, q, mask;
        logic signed [10:0] ex;
        logic [10:0]        shw;
        logic [5:0]         sh;
        logic [7:0]         ef;
        logic               so, inc;
        logic [30:0]        word;
        logic [31:0]        res;
        lz   = lzc48(m.p);
        pn   = m.p << lz;
        ex   = m.e - $signed({5'b0, lz});
        shw  = 11'(11'sd1 - ex);
        sh   = '0;
        q    = pn;
        so   = 1'b0;
        ef   = ex[7:0];
        mask = '0;
        if (ex < 11'sd1) begin
            sh   = ($signed(shw) > 11'sd48) ? 6'd48 : shw[5:0];
            q    = pn >> sh;
            mask = ~(48'hFFFF_FFFF_FFFF << sh);
            so   = |(pn & mask);
            ef   = '0;
        end
        word = {ef, q[46:24]};
        inc  = q[23] & ((|q[22:0]) | so | q[24]);
        if (m.nan) begin
            res = CANON_NAN;
        end else if (m.inf || ex >= 11'sd255) begin
            res = {m.sign, EXP_MAX, 23'b0};
        end else if (m.zero) begin
            res = {m.sign, 31'b0};
        end else begin
            res = {m.sign, word + 31'(inc)};
        end
        return res;
    endfunction

    // add, first half: classify, order by magnitude, align the smaller operand
    function automatic t_add_mid add_pre(input logic [31:0] a, input logic [31:0] b);
        t_add_mid    r;
        logic [31:0] bg, sm;
        logic [7:0]  eg, es, d;
        logic        an, bn, ai, bi;
        logic [26:0] sext, smask;
        an = (a[30:23] == EXP_MAX) && (a[22:0] != '0);
        bn = (b[30:23] == EXP_MAX) && (b[22:0] != '0);
        ai = (a[30:23] == EXP_MAX) && (a[22:0] == '0);
        bi = (b[30:23] == EXP_MAX) && (b[22:0] == '0);
        if (a[30:0] >= b[30:0]) begin
            bg = a;
            sm = b;
        end else begin
            bg = b;
            sm = a;
        end
        eg    = (bg[30:23] == '0) ? 8'd1 : bg[30:23];
        es    = (sm[30:23] == '0) ? 8'd1 : sm[30:23];
        d     = eg - es;
        sext  = {sm[30:23] != '0, sm[22:0], 3'b000};
        smask = '0;
        r.nan       = an | bn | (ai & bi & (a[31] != b[31]));
        r.inf       = ai | bi;
        r.inf_sign  = ai ? a[31] : b[31];
        r.sign      = bg[31];
        r.sub       = a[31] ^ b[31];
        r.zero_sign = a[31] & b[31];
        r.e         = eg;
        r.big       = {bg[30:23] != '0, bg[22:0], 3'b000};
        if (d >= 8'd27) begin
            r.sml = {26'b0, sext != '0};
        end else begin
            smask = ~(27'h7FF_FFFF << d[4:0]);
            r.sml = (sext >> d[4:0]) | {26'b0, |(sext & smask)};
        end
        return r;
    endfunction

    // add, second half: sum, normalize and round to nearest even
    function automatic logic [31:0] add_post(input t_add_mid r);
        logic [27:0] sum;
        logic [26:0] m;
        logic [4:0]  lz;
        logic [7:0]  lim, sh;
        logic [8:0]  ex;
        logic [7:0]  ef;
        logic [30:0] word;
        logic        inc;
        logic [31:0] res;
        sum = r.sub ? ({1'b0, r.big} - {1'b0, r.sml}) : ({1'b0, r.big} + {1'b0, r.sml});
        lz  = lzc27(sum[26:0]);
        lim = r.e - 8'd1;
        sh  = '0;
        if (sum[27]) begin
            m  = {sum[27:2], sum[1] | sum[0]};
            ex = {1'b0, r.e} + 9'd1;
        end else begin
            sh = ({3'b0, lz} < lim) ? {3'b0, lz} : lim;
            m  = sum[26:0] << sh;
            ex = {1'b0, r.e} - {1'b0, sh};
        end
        ef   = m[26] ? ex[7:0] : 8'd0;
        word = {ef, m[25:3]};
        inc  = m[2] & (m[1] | m[0] | m[3]);
        if (r.nan) begin
            res = CANON_NAN;
        end else if (r.inf) begin
            res = {r.inf_sign, EXP_MAX, 23'b0};
        end else if (sum == '0) begin
            res = {r.zero_sign, 31'b0};
        end else if (ex >= 9'd255) begin
            res = {r.sign, EXP_MAX, 23'b0};
        end else begin
            res = {r.sign, word + 31'(inc)};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### sv/fisn_in_if.sv
// operand channel interface
`default_nettype none
interface fisn_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] operand_bits;
    modport source (output valid, output operand_bits, input ready);
    modport sink (input valid, input operand_bits, output ready);
endinterface
`default_nettype wire

### sv/fisn_out_if.sv
// result channel interface
`default_nettype none
interface fisn_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;
    modport source (output valid, output result_bits, input ready);
    modport sink (input valid, input result_bits, output ready);
endinterface
`default_nettype wire

### sv/fast_inverse_sqrt_newton.sv
// top level: pipelined fast reciprocal square root with one newton step
//
// operands arrive on i_in (valid/ready), results leave on o_out (valid/ready);
// one transfer on i_in gives exactly one transfer on o_out, in order
// the seed is magic_constant minus the operand bits shifted right arithmetically,
// refined by y*(1.5 - ((x*0.5)*y)*y) in single precision, nearest even
// ten register stages: each of the four multiplies and the subtract takes two
// (product or alignment, then normalize and round); the last one is the
// output register
// o_out.valid is the last of the valid flags that shift along with the data, so an
// output transfer comes only after the item has passed all ten register stages
// throughput is one item per cycle while the receiver takes results
// when the receiver stalls with a result waiting, the whole pipe holds,
// bubbles in the pipe do not close up and i_in.ready drops
// i_cfg_we writes magic_constant; write it only while the pipe is empty
// synchronous active low reset empties the pipe and restores the constant
// any nan result leaves as 0x7fc00000
`default_nettype none
module fast_inverse_sqrt_newton (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    fisn_in_if.sink          i_in,
    fisn_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data
);
    import fisn_pkg::*;

    localparam int Depth = 10;

    logic [31:0]      r_magic;
    logic [Depth-1:0] r_vld;
    logic             w_en;
    logic [31:0]      w_seed;
    logic [31:0]      w_res;

    t_mul_mid    r_m1, r_m3, r_m5, r_m9;
    t_add_mid    r_a7;
    logic [31:0] r_f2, r_f4, r_f6, r_f8, r_res;
    logic [31:0] r_y1, r_y2, r_y3, r_y4, r_y5, r_y6, r_y7, r_y8;

    assign w_en   = !r_vld[Depth-1] || o_out.ready;
    assign w_seed = r_magic - {i_in.operand_bits[31], i_in.operand_bits[31:1]};

    assign i_in.ready        = w_en;
    assign o_out.valid       = r_vld[Depth-1];
    assign o_out.result_bits = r_res;

    always_comb begin
        w_res = mul_post(r_m9);
        if (w_res[30:23] == EXP_MAX && w_res[22:0] != '0) begin
            w_res = CANON_NAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MAGIC_RESET;
        end else if (i_cfg_we) begin
            r_magic <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Depth-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1  <= mul_pre(i_in.operand_bits, F_HALF);
            r_y1  <= w_seed;
            r_f2  <= mul_post(r_m1);
            r_y2  <= r_y1;
            r_m3  <= mul_pre(r_f2, r_y2);
            r_y3  <= r_y2;
            r_f4  <= mul_post(r_m3);
            r_y4  <= r_y3;
            r_m5  <= mul_pre(r_f4, r_y4);
            r_y5  <= r_y4;
            r_f6  <= mul_post(r_m5);
            r_y6  <= r_y5;
            r_a7  <= add_pre(F_THREE_HALF, {~r_f6[31], r_f6[30:0]});
            r_y7  <= r_y6;
            r_f8  <= add_post(r_a7);
            r_y8  <= r_y7;
            r_m9  <= mul_pre(r_y8, r_f8);
            r_res <= w_res;
        end
    end

`ifndef SYNTHESIS
    a_rst_empty : assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("pipe not empty after reset");
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld) && $stable(r_res))
        else $error("pipe moved during stall");
    a_enter : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("transfer lost at pipe entry");
    a_canon : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && r_res[30:23] == EXP_MAX |-> r_res[22:0] == '0 || r_res == CANON_NAN)
        else $error("non canonical nan on output");
`endif

endmodule
`default_nettype wire

### verif/testbench.sv
// testbench for the fast reciprocal square root pipeline with a bit-exact float predictor
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import fisn_pkg::*;

    typedef struct {
        logic [31:0] operand;
        bit          typed;
        logic [31:0] result;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;

    fisn_in_if  in_ch ();
    fisn_out_if out_ch ();

    fast_inverse_sqrt_newton DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    logic [31:0] magic;
    logic [31:0] pending_results[$];
    bit          calm;
    bit          failed;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] fp_round_pack(input logic sgn, input logic [127:0] m,
                                                  input int e);
        int          p;
        longint      ex, s, bits;
        logic [127:0] q;
        logic        g, st;
        p = 0;
        for (int i = 0; i < 128; i++) if (m[i]) p = i;
        ex = p + e + 127;
        s = (ex >= 1) ? p - 23 : -149 - e;
        if (s <= 0) begin
            q = m << (-s);
            g = 1'b0;
            st = 1'b0;
        end else if (s > 129) begin
            q = '0;
            g = 1'b0;
            st = 1'b1;
        end else begin
            q = m >> s;
            g = (s <= 128) ? m[s-1] : 1'b0;
            st = |(m & ((128'd1 << (s - 1)) - 128'd1));
        end
        bits = ((ex >= 1) ? (ex - 1) <<< 23 : 64'sd0) + longint'(q[31:0])
               + longint'(g & (st | q[0]));
        if (bits >= 64'h7F80_0000) return {sgn, EXP_MAX, 23'b0};
        return {sgn, bits[30:0]};
    endfunction

    function automatic bit is_nan(input logic [31:0] v);
        return v[30:23] == EXP_MAX && v[22:0] != '0;
    endfunction

    function automatic bit is_inf(input logic [31:0] v);
        return v[30:23] == EXP_MAX && v[22:0] == '0;
    endfunction

    function automatic int unb_exp(input logic [31:0] v);
        return ((v[30:23] == 8'd0) ? 1 : int'(v[30:23])) - 150;
    endfunction

    function automatic logic [127:0] signif(input logic [31:0] v);
        return 128'({v[30:23] != 8'd0, v[22:0]});
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        bit az, bz;
        az = a[30:0] == '0;
        bz = b[30:0] == '0;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && bz) || (az && is_inf(b)))
            return CANON_NAN;
        if (is_inf(a) || is_inf(b)) return {a[31] ^ b[31], EXP_MAX, 23'b0};
        if (az || bz) return {a[31] ^ b[31], 31'b0};
        return fp_round_pack(a[31] ^ b[31], signif(a) * signif(b), unb_exp(a) + unb_exp(b));
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [127:0] ma, mb;
        int           ea, eb, e0;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31]))
            return CANON_NAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == '0 && b[30:0] == '0) return {a[31] & b[31], 31'b0};
        ma = signif(a);
        mb = signif(b);
        ea = unb_exp(a);
        eb = unb_exp(b);
        e0 = (ea < eb) ? ea : eb;
        if (ea - eb > 100) begin
            e0 = ea - 100;
            mb = 128'(mb != '0);
            eb = e0;
        end else if (eb - ea > 100) begin
            e0 = eb - 100;
            ma = 128'(ma != '0);
            ea = e0;
        end
        ma = ma << (ea - e0);
        mb = mb << (eb - e0);
        if (a[31] == b[31]) return fp_round_pack(a[31], ma + mb, e0);
        if (ma == mb) return 32'h0;
        if (ma > mb) return fp_round_pack(a[31], ma - mb, e0);
        return fp_round_pack(b[31], mb - ma, e0);
    endfunction

    function automatic logic [31:0] rsqrt_expected(input logic [31:0] x, input logic [31:0] k);
        logic [31:0] half_x, y, t1, t2, r;
        half_x = fp_mul(x, F_HALF);
        y = k - ((x >> 1) | (x & 32'h8000_0000));
        t1 = fp_mul(half_x, y);
        t2 = fp_mul(t1, y);
        r = fp_mul(y, fp_add(F_THREE_HALF, {~t2[31], t2[30:0]}));
        if (is_nan(r)) r = CANON_NAN;
        return r;
    endfunction

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v[30:23] = 8'd0;
            1: v[30:23] = EXP_MAX;
            2: v[30:23] = 8'($urandom_range(1, 4));
            3: v[30:23] = 8'($urandom_range(250, 254));
            4, 5, 6: begin
                v[31] = 1'b0;
                v[30:23] = 8'($urandom_range(100, 154));
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_operand(input logic [31:0] op, input bit typed, input logic [31:0] res);
        while (!calm && $urandom_range(99) < 23) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operand_bits <= op;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.insert(pending_results.size(),
                               typed ? res : rsqrt_expected(op, magic));
    endtask

    task automatic drain_and_write(input logic [31:0] k);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= k;
        magic = k;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // receiver side: check and stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected transfer result_bits=%h", out_ch.result_bits);
                    failed = 1'b1;
                end else begin
                    if (out_ch.result_bits !== pending_results[0]) begin
                        $error("result_bits expected %h actual %h",
                               pending_results[0], out_ch.result_bits);
                        failed = 1'b1;
                    end
                    void'(pending_results.pop_front());
                end
            end
            out_ch.ready <= calm || ($urandom_range(99) >= 23);
        end else begin
            out_ch.ready <= 1'b0;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 3000) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        t_row        rows[20];
        logic [31:0] settings[5];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.operand_bits = '0;
        magic = MAGIC_RESET;
        calm = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows = '{
            '{32'h7FC0_0001, 1'b1, CANON_NAN},
            '{32'hFFFF_FFFF, 1'b1, CANON_NAN},
            '{32'h7F80_0001, 1'b1, CANON_NAN},
            '{32'h0000_0000, 1'b0, 32'h0},
            '{32'h8000_0000, 1'b0, 32'h0},
            '{32'h7F80_0000, 1'b0, 32'h0},
            '{32'hFF80_0000, 1'b0, 32'h0},
            '{32'h0000_0001, 1'b0, 32'h0},
            '{32'h007F_FFFF, 1'b0, 32'h0},
            '{32'h0080_0000, 1'b0, 32'h0},
            '{32'h7F7F_FFFF, 1'b0, 32'h0},
            '{32'h3F80_0000, 1'b0, 32'h0},
            '{32'h4080_0000, 1'b0, 32'h0},
            '{32'h3E80_0000, 1'b0, 32'h0},
            '{32'hBF80_0000, 1'b0, 32'h0},
            '{32'h8000_0001, 1'b0, 32'h0},
            '{32'h4049_0FDB, 1'b0, 32'h0},
            '{32'h5555_5555, 1'b0, 32'h0},
            '{32'hAAAA_AAAA, 1'b0, 32'h0},
            '{32'h0000_0002, 1'b0, 32'h0}
        };
        foreach (rows[i]) send_operand(rows[i].operand, rows[i].typed, rows[i].result);

        settings = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h5F37_5A86, MAGIC_RESET};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) drain_and_write(settings[ph-1]);
            for (int n = 0; n < 322; n++) begin
                calm = (ph == 2 && n >= 50 && n < 200);
                send_operand(random_operand(), 0, 0);
            end
            calm = 1'b0;
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire

### fast_inverse_sqrt_newton.f
sv/fisn_pkg.sv
sv/fisn_in_if.sv
sv/fisn_out_if.sv
sv/fast_inverse_sqrt_newton.sv
verif/testbench.sv
